>>> design/multi_context_fragment_reassembler_core_macros.svh
// ----------------------------------------------------------------------------
// multi_context_fragment_reassembler_core_macros
// Assertion macros for the fragment reassembler.
// ----------------------------------------------------------------------------
`ifndef MULTI_CONTEXT_FRAGMENT_REASSEMBLER_CORE_MACROS_SVH
`define MULTI_CONTEXT_FRAGMENT_REASSEMBLER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define MCFR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define MCFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/mcfr_pkg.sv
// ----------------------------------------------------------------------------
// mcfr_pkg
// Types and constants shared by the fragment reassembler modules.
// ----------------------------------------------------------------------------
package mcfr_pkg;

	localparam int unsigned CONTEXTS = 4;
	localparam int unsigned CTX_W    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int unsigned CFG_W    = 64;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [15:0] CRC_POLY   = 16'h8408;
	localparam logic [15:0] CRC_PRESET = 16'hffff;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SUB0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUB1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUB2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUB3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHKCRC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

	// status codes
	localparam logic [2:0] ST_COMPLETE = 3'd0;
	localparam logic [2:0] ST_CRC_ERR  = 3'd1;
	localparam logic [2:0] ST_TRUNC    = 3'd2;
	localparam logic [2:0] ST_SEQ_ERR  = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_NO_CTX   = 3'd5;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [6:0] sender_id;
		logic [7:0] stream_tag;
		logic [7:0] sequence_req;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic [7:0] byte_c;
		logic [7:0] byte_d;
		logic [7:0] byte_e;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload;
		logic [7:0]  stream;
		logic [1:0]  context_index;
		logic [2:0]  status;
		logic [15:0] byte_count;
		logic        last;
	} out_item_t;

	// static configuration seen by the sequencer
	typedef struct packed {
		logic        check_crc;
		logic [15:0] receive_limit;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// one bit step of the reflected CRC
	function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic d);
		logic [15:0] r;
		r = {1'b0, crc[15:1]};
		if (crc[0] ^ d) begin
			r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	// context index as seen on the output (low two bits)
	function automatic logic [1:0] ctx_out(input logic [CTX_W-1:0] i);
		logic [CTX_W+1:0] w;
		w = {2'b00, i};
		return w[1:0];
	endfunction

endpackage

>>> design/mcfr_crc_unit.sv
// ----------------------------------------------------------------------------
// mcfr_crc_unit
// Shared CRC-16 engine: folds one byte into the running value, one bit a cycle.
// ----------------------------------------------------------------------------
module mcfr_crc_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] crc_in,
	input  logic [7:0]  data_in,
	output logic        done,
	output logic [15:0] crc_out
);

	logic [15:0] crc_q;
	logic [7:0]  data_q;
	logic [3:0]  cnt_q;
	logic        busy_q;

	// bit-serial loop over the byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q  <= crc_in;
			data_q <= data_in;
		end else if (busy_q) begin
			crc_q  <= mcfr_pkg::crc_bit(crc_q, data_q[0]);
			data_q <= {1'b0, data_q[7:1]};
		end
	end

	assign done    = busy_q && (cnt_q == 4'd7);
	assign crc_out = mcfr_pkg::crc_bit(crc_q, data_q[0]);

endmodule

>>> design/mcfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcfr_cfg_regs
// Configuration registers and stream subscription lookup.
// ----------------------------------------------------------------------------
module mcfr_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcfr_pkg::CFG_W-1:0]         cfg_data,
	input  logic [7:0]                         lookup_stream,
	output logic                               subscribed,
	output mcfr_pkg::cfg_t                     cfg
);

	logic [63:0] sub_q [4];
	logic        chk_q;
	logic [15:0] limit_q;
	logic [15:0] tmo_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				sub_q[k] <= '0;
			end
			chk_q   <= 1'b0;
			limit_q <= 16'd256;
			tmo_q   <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcfr_pkg::REG_SUB0:    sub_q[0] <= cfg_data;
				mcfr_pkg::REG_SUB1:    sub_q[1] <= cfg_data;
				mcfr_pkg::REG_SUB2:    sub_q[2] <= cfg_data;
				mcfr_pkg::REG_SUB3:    sub_q[3] <= cfg_data;
				mcfr_pkg::REG_CHKCRC:  chk_q    <= cfg_data[0];
				mcfr_pkg::REG_LIMIT:   limit_q  <= cfg_data[15:0];
				mcfr_pkg::REG_TIMEOUT: tmo_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign subscribed = sub_q[lookup_stream[7:6]][lookup_stream[5:0]];
	assign cfg = '{check_crc: chk_q, receive_limit: limit_q, timeout_ticks: tmo_q};

endmodule

>>> design/multi_context_fragment_reassembler_core.sv
// ----------------------------------------------------------------------------
// multi_context_fragment_reassembler_core
// Reassembles fragmented long messages over several receive contexts.
// ----------------------------------------------------------------------------
// One request is handled at a time by a sequencer that visits the contexts
// one per cycle, pausing while a staged result waits to go out, and runs
// every payload byte through a shared bit-serial CRC engine (a start state,
// then a wait for the shifts). A tick ages every context and reports each
// timeout; a header scans for the lowest free context and reports when none
// is free; a continuation is matched by stream and sender, then each payload
// byte is folded, emitted and checked, with a closing event and a last state.
// Each result waits in an output register until taken, and any output stall
// holds the sequencer; in_stall is high while a request is busy.
`include "multi_context_fragment_reassembler_core_macros.svh"

module multi_context_fragment_reassembler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mcfr_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mcfr_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [mcfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcfr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int unsigned N  = mcfr_pkg::CONTEXTS;
	localparam int unsigned CW = mcfr_pkg::CTX_W;
	localparam logic [CW-1:0] LAST_CTX = CW'(N - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_TICK  = 9'b000000010,
		S_SCAN  = 9'b000000100,
		S_HDR   = 9'b000001000,
		S_BYTE  = 9'b000010000,
		S_CRC   = 9'b000100000,
		S_CHECK = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, ret_q;
	mcfr_pkg::in_item_t req_q;
	mcfr_pkg::cfg_t cfg;
	logic subscribed;

	// per-context store
	logic [N-1:0] busy_q;
	logic [7:0]  ctx_stream_q [N];
	logic [6:0]  ctx_sender_q [N];
	logic [15:0] msg_len_q    [N];
	logic [15:0] hdr_crc_q    [N];
	logic [15:0] run_crc_q    [N];
	logic [15:0] rx_cnt_q     [N];
	logic [7:0]  next_seq_q   [N];
	logic [15:0] idle_q       [N];

	logic [CW-1:0] idx_q;
	logic [2:0]    byte_q;
	logic [2:0]    nres_q;

	logic [7:0]  cur_byte;
	logic        crc_start, crc_done;
	logic [15:0] crc_out;

	// output register
	logic                 ovalid_q;
	mcfr_pkg::out_item_t  odata_q;
	logic                 pend_q;
	mcfr_pkg::out_item_t  pend_item_q;

	mcfr_cfg_regs u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.lookup_stream(req_q.stream_tag), .subscribed, .cfg
	);

	mcfr_crc_unit u_crc (
		.clk, .arst_n, .start(crc_start), .crc_in(run_crc_q[idx_q]),
		.data_in(cur_byte), .done(crc_done), .crc_out
	);

	always_comb begin
		unique case (byte_q)
			3'd0:    cur_byte = req_q.byte_a;
			3'd1:    cur_byte = req_q.byte_b;
			3'd2:    cur_byte = req_q.byte_c;
			3'd3:    cur_byte = req_q.byte_d;
			default: cur_byte = req_q.byte_e;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	logic idx_last;
	logic [15:0] inc_cnt;
	logic [15:0] idle_inc;
	logic [15:0] want;
	logic        tmo_hit;
	logic        closing;
	assign idx_last = (idx_q == LAST_CTX);
	assign inc_cnt  = rx_cnt_q[idx_q] + 16'd1;
	assign idle_inc = (idle_q[idx_q] == 16'hffff) ? 16'hffff : idle_q[idx_q] + 16'd1;
	assign want     = (cfg.check_crc && hdr_crc_q[idx_q] != 16'd0) ?
		{~run_crc_q[idx_q][7:0], ~run_crc_q[idx_q][15:8]} : 16'd0;
	assign tmo_hit  = busy_q[idx_q] && (nres_q != 3'd6) && (idle_inc >= cfg.timeout_ticks);
	// the byte being folded ends the message (completion or limit)
	assign closing  = (inc_cnt >= msg_len_q[idx_q]) || (inc_cnt >= cfg.receive_limit);
	assign crc_start = (state_q == S_BYTE);

	// results are staged in pend, then moved to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (!ovalid_q || !out_stall) begin
			ovalid_q <= pend_q && state_q == S_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		if ((!ovalid_q || !out_stall) && pend_q && state_q == S_EMIT) begin
			odata_q <= pend_item_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			busy_q  <= '0;
			pend_q  <= 1'b0;
			idx_q   <= '0;
			byte_q  <= '0;
			nres_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						nres_q  <= '0;
						byte_q  <= '0;
						if (in_data.operation == mcfr_pkg::OP_TICK) begin
							state_q <= S_TICK;
						end else if (in_data.sequence_req == 8'd0) begin
							state_q <= S_HDR;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				// age one context per cycle, pausing while a held timeout goes out; a timeout
				// is held until the next one or the end of the scan shows whether it is last
				S_TICK: begin
					if (tmo_hit && pend_q) begin
						ret_q   <= S_TICK;
						state_q <= S_EMIT;
					end else begin
						if (busy_q[idx_q] && nres_q != 3'd6) begin
							idle_q[idx_q] <= idle_inc;
						end
						if (tmo_hit) begin
							busy_q[idx_q] <= 1'b0;
							pend_q <= 1'b1;
							nres_q <= nres_q + 3'd1;
							pend_item_q <= '{kind: 1'b1, payload: 8'd0,
								stream: ctx_stream_q[idx_q],
								context_index: mcfr_pkg::ctx_out(idx_q),
								status: mcfr_pkg::ST_TIMEOUT,
								byte_count: rx_cnt_q[idx_q], last: idx_last};
						end
						if (!idx_last) begin
							idx_q <= idx_q + CW'(1);
						end else if (tmo_hit) begin
							ret_q   <= S_DONE;
							state_q <= S_EMIT;
						end else if (pend_q) begin
							pend_item_q.last <= 1'b1;
							ret_q   <= S_DONE;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				// lowest free context for a header
				S_HDR: begin
					if (req_q.byte_e != 8'd0 || !subscribed) begin
						state_q <= S_DONE;
					end else if (!busy_q[idx_q]) begin
						busy_q[idx_q]       <= 1'b1;
						ctx_stream_q[idx_q] <= req_q.stream_tag;
						ctx_sender_q[idx_q] <= req_q.sender_id;
						msg_len_q[idx_q]    <= {req_q.byte_a, req_q.byte_b};
						hdr_crc_q[idx_q]    <= {req_q.byte_c, req_q.byte_d};
						run_crc_q[idx_q]    <= mcfr_pkg::CRC_PRESET;
						rx_cnt_q[idx_q]     <= 16'd0;
						next_seq_q[idx_q]   <= 8'd1;
						idle_q[idx_q]       <= 16'd0;
						state_q <= S_DONE;
					end else if (idx_last) begin
						pend_q <= 1'b1;
						ret_q  <= S_DONE;
						pend_item_q <= '{kind: 1'b1, payload: 8'd0,
							stream: req_q.stream_tag, context_index: 2'd0,
							status: mcfr_pkg::ST_NO_CTX, byte_count: 16'd0,
							last: 1'b1};
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				// match a continuation by stream and sender
				S_SCAN: begin
					if (busy_q[idx_q] && ctx_stream_q[idx_q] == req_q.stream_tag &&
							ctx_sender_q[idx_q] == req_q.sender_id) begin
						if (req_q.sequence_req != next_seq_q[idx_q]) begin
							busy_q[idx_q] <= 1'b0;
							pend_q <= 1'b1;
							ret_q  <= S_DONE;
							pend_item_q <= '{kind: 1'b1, payload: 8'd0,
								stream: req_q.stream_tag,
								context_index: mcfr_pkg::ctx_out(idx_q),
								status: mcfr_pkg::ST_SEQ_ERR,
								byte_count: rx_cnt_q[idx_q], last: 1'b1};
							state_q <= S_EMIT;
						end else begin
							next_seq_q[idx_q] <= next_seq_q[idx_q] + 8'd1;
							state_q <= S_BYTE;
						end
					end else if (idx_last) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_BYTE: begin
					state_q <= S_CRC;
				end
				// wait for the byte to fold into the CRC, then emit it; it is
				// the final result when it is the fifth byte and closes nothing
				S_CRC: begin
					if (crc_done) begin
						run_crc_q[idx_q] <= crc_out;
						rx_cnt_q[idx_q]  <= inc_cnt;
						idle_q[idx_q]    <= 16'd0;
						pend_q <= 1'b1;
						pend_item_q <= '{kind: 1'b0, payload: cur_byte,
							stream: req_q.stream_tag,
							context_index: mcfr_pkg::ctx_out(idx_q),
							status: mcfr_pkg::ST_COMPLETE, byte_count: inc_cnt,
							last: (byte_q == 3'd4) && !closing};
						ret_q   <= S_CHECK;
						state_q <= S_EMIT;
					end
				end
				// completion, limit, next byte, or end of the fragment
				S_CHECK: begin
					if (rx_cnt_q[idx_q] >= msg_len_q[idx_q] ||
							rx_cnt_q[idx_q] >= cfg.receive_limit) begin
						busy_q[idx_q] <= 1'b0;
						pend_q <= 1'b1;
						ret_q  <= S_DONE;
						pend_item_q <= '{kind: 1'b1, payload: 8'd0,
							stream: req_q.stream_tag,
							context_index: mcfr_pkg::ctx_out(idx_q),
							status: (rx_cnt_q[idx_q] >= msg_len_q[idx_q]) ?
								((hdr_crc_q[idx_q] != want) ? mcfr_pkg::ST_CRC_ERR :
								mcfr_pkg::ST_COMPLETE) : mcfr_pkg::ST_TRUNC,
							byte_count: rx_cnt_q[idx_q], last: 1'b1};
						state_q <= S_EMIT;
					end else if (byte_q == 3'd4) begin
						state_q <= S_DONE;
					end else begin
						byte_q  <= byte_q + 3'd1;
						state_q <= S_BYTE;
					end
				end
				// hand the staged result to the output register
				S_EMIT: begin
					if (!ovalid_q || !out_stall) begin
						pend_q  <= 1'b0;
						state_q <= ret_q;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
		end
	end

	`MCFR_ASSERT_IMPL(a_emit_pending, state_q == S_EMIT, pend_q)
	`MCFR_ASSERT_NEXT(a_stall_busy, state_q == S_DONE, state_q == S_IDLE)
	`MCFR_ASSERT_IMPL(a_out_kind, out_valid && out_data.kind == 1'b0,
		out_data.status == mcfr_pkg::ST_COMPLETE)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frames and ticks into the fragment reassembler over several register
// settings, predicts every payload byte and status event, and checks them.
// ----------------------------------------------------------------------------

import mcfr_pkg::*;

localparam logic KIND_BYTE  = 1'b0;
localparam logic KIND_EVENT = 1'b1;
localparam int   MAX_EVENTS = 6;

// reflected CRC-16 over one byte
function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] data);
	logic [15:0] c;
	c = crc;
	for (int b = 0; b < 8; b++) begin
		if (c[0] ^ data[b]) begin
			c = {1'b0, c[15:1]} ^ 16'h8408;
		end else begin
			c = {1'b0, c[15:1]};
		end
	end
	return c;
endfunction

// inversion and byte swap of the finished CRC
function automatic logic [15:0] crc16_close(input logic [15:0] crc);
	logic [15:0] inv;
	inv = ~crc;
	return {inv[7:0], inv[15:8]};
endfunction

class reassembly_scoreboard;
	logic [63:0] sub_mask [4];
	logic        crc_on;
	logic [15:0] rx_limit;
	logic [15:0] idle_limit;

	logic        busy      [4];
	logic [7:0]  ctx_stream [4];
	logic [6:0]  ctx_sender [4];
	logic [15:0] msg_len   [4];
	logic [15:0] hdr_crc   [4];
	logic [15:0] run_crc   [4];
	logic [15:0] rx_count  [4];
	logic [7:0]  want_seq  [4];
	logic [15:0] idle_cnt  [4];

	out_item_t   awaited [$];
	int          errors;

	function new();
		for (int i = 0; i < 4; i++) begin
			sub_mask[i] = '0;
			busy[i] = 1'b0;
		end
		crc_on = 1'b0;
		rx_limit = 16'd256;
		idle_limit = 16'd1000;
		errors = 0;
	endfunction

	function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
			REG_SUB0, REG_SUB1, REG_SUB2, REG_SUB3: sub_mask[idx[1:0]] = val;
			REG_CHKCRC: crc_on = val[0];
			REG_LIMIT: rx_limit = val[15:0];
			REG_TIMEOUT: idle_limit = val[15:0];
			default: ;
		endcase
	endfunction

	function out_item_t event_of(input logic kind, input logic [7:0] data,
			input logic [7:0] stream, input int ctx, input logic [2:0] st,
			input logic [15:0] count);
		out_item_t o;
		o.kind = kind;
		o.payload = data;
		o.stream = stream;
		o.context_index = ctx[1:0];
		o.status = st;
		o.byte_count = count;
		o.last = 1'b0;
		return o;
	endfunction

	// work out what one accepted request produces
	function void note_request(input in_item_t r);
		out_item_t   res [$];
		logic [7:0]  d [5];
		logic [15:0] want;
		int          i;
		d[0] = r.byte_a; d[1] = r.byte_b; d[2] = r.byte_c; d[3] = r.byte_d; d[4] = r.byte_e;
		if (r.operation == OP_TICK) begin
			// age open contexts, lowest first
			for (i = 0; i < 4 && res.size() < MAX_EVENTS; i++) begin
				if (busy[i]) begin
					if (idle_cnt[i] != 16'hffff) idle_cnt[i]++;
					if (idle_cnt[i] >= idle_limit) begin
						res.push_back(event_of(KIND_EVENT, 8'd0, ctx_stream[i], i,
							ST_TIMEOUT, rx_count[i]));
						busy[i] = 1'b0;
					end
				end
			end
		end else if (r.sequence_req == 8'd0) begin
			// header
			if (d[4] == 8'd0 && sub_mask[r.stream_tag[7:6]][r.stream_tag[5:0]]) begin
				for (i = 0; i < 4; i++) if (!busy[i]) break;
				if (i < 4) begin
					busy[i] = 1'b1;
					ctx_stream[i] = r.stream_tag;
					ctx_sender[i] = r.sender_id;
					msg_len[i] = {d[0], d[1]};
					hdr_crc[i] = {d[2], d[3]};
					run_crc[i] = 16'hffff;
					rx_count[i] = '0;
					want_seq[i] = 8'd1;
					idle_cnt[i] = '0;
				end else begin
					res.push_back(event_of(KIND_EVENT, 8'd0, r.stream_tag, 0, ST_NO_CTX, 16'd0));
				end
			end
		end else begin
			// continuation
			for (i = 0; i < 4; i++)
				if (busy[i] && ctx_stream[i] == r.stream_tag && ctx_sender[i] == r.sender_id)
					break;
			if (i < 4) begin
				if (r.sequence_req != want_seq[i]) begin
					res.push_back(event_of(KIND_EVENT, 8'd0, r.stream_tag, i, ST_SEQ_ERR,
						rx_count[i]));
					busy[i] = 1'b0;
				end else begin
					for (int j = 0; j < 5; j++) begin
						run_crc[i] = crc16_add(run_crc[i], d[j]);
						rx_count[i] = rx_count[i] + 16'd1;
						idle_cnt[i] = '0;
						res.push_back(event_of(KIND_BYTE, d[j], r.stream_tag, i, ST_COMPLETE,
							rx_count[i]));
						if (rx_count[i] >= msg_len[i]) begin
							want = (crc_on && hdr_crc[i] != 16'd0) ? crc16_close(run_crc[i]) : 16'd0;
							res.push_back(event_of(KIND_EVENT, 8'd0, r.stream_tag, i,
								(hdr_crc[i] != want) ? ST_CRC_ERR : ST_COMPLETE, rx_count[i]));
							busy[i] = 1'b0;
							break;
						end else if (rx_count[i] >= rx_limit) begin
							res.push_back(event_of(KIND_EVENT, 8'd0, r.stream_tag, i, ST_TRUNC,
								rx_count[i]));
							busy[i] = 1'b0;
							break;
						end
					end
					want_seq[i] = want_seq[i] + 8'd1;
				end
			end
		end
		if (res.size() > 0) res[res.size()-1].last = 1'b1;
		foreach (res[k]) awaited.push_back(res[k]);
	endfunction

	function void check_result(input out_item_t got);
		out_item_t exp;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %p", $realtime, got);
			errors++;
			return;
		end
		exp = awaited.pop_front();
		if (got.kind !== exp.kind || got.payload !== exp.payload ||
				got.stream !== exp.stream || got.context_index !== exp.context_index ||
				got.status !== exp.status || got.byte_count !== exp.byte_count ||
				got.last !== exp.last) begin
			$display("%0t: result mismatch, expected %p, actual %p", $realtime, exp, got);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 150;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	reassembly_scoreboard sb = new();

	int          burst_left = 0;
	int          frames_sent = 0;
	int          stall_left = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;

	// open messages being generated
	logic        slot_open   [4];
	logic [7:0]  slot_stream [4];
	logic [6:0]  slot_sender [4];
	logic [7:0]  slot_seq    [4];
	logic [7:0]  slot_bytes  [4][0:127];
	int          slot_pos    [4];
	int          slot_end    [4];

	multi_context_fragment_reassembler_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// result side: stall pattern with changing density
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(1, 60);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end else begin
			stall_left--;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t frame(input logic [6:0] sender, input logic [7:0] stream,
			input logic [7:0] seq, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e);
		in_item_t f;
		f = {OP_FRAME, sender, stream, seq, a, b, c, d, e};
		return f;
	endfunction

	// one request, then either carry on in the burst or pause
	task automatic push(input in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(it);
		frames_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 15);
		end else begin
			burst_left--;
		end
	endtask

	task automatic tick();
		in_item_t t;
		t = {$urandom, $urandom};
		t.operation = OP_TICK;
		push(t);
	endtask

	// wait until the block has gone quiet, then load all registers
	task automatic load_registers(input logic [63:0] m0, input logic [63:0] m1,
			input logic [63:0] m2, input logic [63:0] m3, input logic crc_on,
			input logic [15:0] lim, input logic [15:0] tmo);
		logic [CFG_W-1:0] vals [7];
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		vals = '{m0, m1, m2, m3, {63'd0, crc_on}, {48'd0, lim}, {48'd0, tmo}};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(i[CFG_IDX_W-1:0], vals[i]);
		end
		cfg_we <= 1'b0;
		for (int k = 0; k < 4; k++) slot_open[k] = 1'b0;
	endtask

	// expected header CRC over the first max(len,1) bytes of a slot
	function automatic logic [15:0] slot_crc(input int k, input int n);
		logic [15:0] c;
		c = 16'hffff;
		for (int i = 0; i < ((n < 1) ? 1 : n); i++) c = crc16_add(c, slot_bytes[k][i]);
		return crc16_close(c);
	endfunction

	// open a message in slot k, sending its header
	task automatic open_message(input int k, input logic [7:0] stream, input logic [6:0] sender);
		int          len;
		logic [15:0] hcrc;
		case ($urandom_range(0, 9))
			0: len = $urandom_range(31, 120);
			1: len = $urandom_range(0, 65535);
			default: len = $urandom_range(0, 30);
		endcase
		slot_end[k] = (len > 120) ? 40 : ((len < 1) ? 5 : ((len + 4) / 5) * 5);
		for (int i = 0; i < slot_end[k]; i++) slot_bytes[k][i] = 8'($urandom);
		case ($urandom_range(0, 2))
			0: hcrc = 16'd0;
			1: hcrc = 16'($urandom);
			default: hcrc = (len > 120) ? 16'($urandom) : slot_crc(k, len);
		endcase
		slot_open[k] = 1'b1;
		slot_stream[k] = stream;
		slot_sender[k] = sender;
		slot_seq[k] = 8'd1;
		slot_pos[k] = 0;
		push(frame(sender, stream, 8'd0, len[15:8], len[7:0], hcrc[15:8], hcrc[7:0], 8'd0));
	endtask

	// next fragment of slot k, sometimes with a broken sequence number
	task automatic continue_message(input int k);
		logic [7:0] seq;
		int         p;
		p = slot_pos[k];
		seq = slot_seq[k];
		if ($urandom_range(0, 19) == 0) begin
			seq = seq + 8'($urandom_range(1, 254));
			if (seq == 8'd0) seq = 8'd1;
			slot_open[k] = 1'b0;
		end
		push(frame(slot_sender[k], slot_stream[k], seq, slot_bytes[k][p],
			slot_bytes[k][p+1], slot_bytes[k][p+2], slot_bytes[k][p+3], slot_bytes[k][p+4]));
		slot_seq[k] = slot_seq[k] + 8'd1;
		slot_pos[k] = p + 5;
		if (slot_pos[k] >= slot_end[k]) slot_open[k] = 1'b0;
	endtask

	// mostly well-formed interleaved messages, plus ticks and noise
	task automatic random_traffic(input int count);
		int       target;
		int       k;
		int       pick;
		in_item_t noise;
		target = frames_sent + count;
		while (frames_sent < target) begin
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, 3);
			if (pick < 8) begin
				tick();
			end else if (pick < 13) begin
				noise = {$urandom, $urandom};
				noise.operation = OP_FRAME;
				push(noise);
			end else if (pick < 30 || !slot_open[k]) begin
				if (!slot_open[k]) open_message(k, 8'($urandom), 7'($urandom));
				else tick();
			end else begin
				continue_message(k);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		for (int k = 0; k < 4; k++) slot_open[k] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases: CRC on, short timeout, edge stream ids subscribed
		load_registers('1, '0, {$urandom, $urandom}, 64'h8000_0000_0000_0001,
			1'b1, 16'd256, 16'd3);
		// correct CRC over seven bytes on stream 255, sender 0
		slot_end[0] = 10;
		for (int i = 0; i < 10; i++) slot_bytes[0][i] = (i == 0) ? 8'hff : 8'($urandom);
		slot_bytes[0][1] = 8'h00;
		begin
			logic [15:0] c;
			c = slot_crc(0, 7);
			push(frame(7'd0, 8'd255, 8'd0, 8'd0, 8'd7, c[15:8], c[7:0], 8'd0));
		end
		push(frame(7'd0, 8'd255, 8'd1, slot_bytes[0][0], slot_bytes[0][1], slot_bytes[0][2],
			slot_bytes[0][3], slot_bytes[0][4]));
		push(frame(7'd0, 8'd255, 8'd2, slot_bytes[0][5], slot_bytes[0][6], 8'hff, 8'h00, 8'hff));
		// zero length with a wrong CRC: one byte then a CRC error
		push(frame(7'h7f, 8'd0, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'd0));
		push(frame(7'h7f, 8'd0, 8'd1, 8'h00, 8'hff, 8'h55, 8'haa, 8'h01));
		// header with flags set, and a continuation that matches nothing
		push(frame(7'd3, 8'd1, 8'd0, 8'd0, 8'd4, 8'd0, 8'd0, 8'hff));
		push(frame(7'd3, 8'd1, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5));
		// stream not subscribed
		push(frame(7'd3, 8'd64, 8'd0, 8'd0, 8'd4, 8'd0, 8'd0, 8'd0));
		// fill all contexts, the same stream twice, then one too many
		push(frame(7'd1, 8'd5, 8'd0, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0));
		push(frame(7'd1, 8'd5, 8'd0, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0));
		push(frame(7'd2, 8'd6, 8'd0, 8'hff, 8'hff, 8'd0, 8'd0, 8'd0));
		push(frame(7'd9, 8'd192, 8'd0, 8'd0, 8'd50, 8'd0, 8'd0, 8'd0));
		push(frame(7'd4, 8'd7, 8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0));
		// wrong sequence hits the lower of the two stream-5 contexts
		push(frame(7'd1, 8'd5, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		// the rest time out on the third tick
		tick();
		tick();
		tick();
		// zero header CRC completes even with checking on
		push(frame(7'd8, 8'd9, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0));
		push(frame(7'd8, 8'd9, 8'd1, 8'hde, 8'had, 8'hbe, 8'hef, 8'h00));
		random_traffic(40);

		// limit of one byte, immediate timeouts, CRC checking off
		load_registers({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 1'b0, 16'd1, 16'd1);
		random_traffic(50);

		// everything subscribed, middling limit and timeout
		load_registers('1, '1, '1, '1, 1'b1, 16'd20, 16'd5);
		random_traffic(70);

		// largest limit and timeout
		load_registers('1, '1, '1, '1, 1'b1, 16'hffff, 16'hffff);
		random_traffic(30);

		// drain
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
